// File: hdl/sphere_contact_penalty_force_assert.svh
// Assertion macros for the sphere contact penalty force unit.
`ifndef SPHERE_CONTACT_PENALTY_FORCE_ASSERT_SVH
`define SPHERE_CONTACT_PENALTY_FORCE_ASSERT_SVH
`ifndef SYNTHESIS
`define SCPF_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scpf: same-cycle check failed");
`define SCPF_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scpf: next-cycle check failed");
`else
`define SCPF_ASSERT_IMPLY(lbl, pre, post)
`define SCPF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: hdl/scpf_pkg.sv
// Shared constants, types and fixed-point helpers of the contact unit.
package scpf_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES = 32;
    localparam logic [15:0] STIFFNESS_RESET = 16'd400;

    typedef logic signed [31:0] q32_t;
    typedef logic signed [32:0] dif_t;
    typedef logic signed [18:0] nrm_t;
    typedef logic signed [51:0] prod_t;

    // Data that rides beside the square root.
    typedef struct packed {
        logic          mode;
        logic          hit;
        logic [30:0]   ar;
        logic [30:0]   br;
        logic [31:0]   sum;
        q32_t [2:0]    a;
        q32_t [2:0]    b;
        nrm_t [2:0]    n;
        dif_t [2:0]    d;
        q32_t          dis;
    } side_t;

    // Data that rides beside the dividers.
    typedef struct packed {
        logic          mode;
        logic          hit;
        q32_t [2:0]    b;
        logic [2:0]    dneg;
        logic          coef_neg;
        logic          dist_zero;
        prod_t [2:0]   pd;
        q32_t [2:0]    ct_pl;
    } mid_t;

    function automatic q32_t sat32(input logic signed [63:0] x);
        q32_t r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < 64'shFFFFFFFF80000000)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // Division by 2^16 that truncates toward zero.
    function automatic logic signed [63:0] trunc_q16(input logic signed [63:0] x);
        logic signed [63:0] adj;
        adj = x + (x[63] ? 64'sd65535 : 64'sd0);
        return adj >>> 16;
    endfunction

endpackage

// File: hdl/sphere_contact_penalty_force.sv
// Sphere-sphere and sphere-plane penalty contact unit in Q16.16 fixed point.
// Throughput: one pair per cycle while the output is not stalled; the 32-stage square root and the 32-stage dividers
// are fully pipelined, and an output stall freezes every stage at once.
// Reset clears all valid bits and loads stiffness with 400; data registers are not reset.
`include "sphere_contact_penalty_force_assert.svh"
module sphere_contact_penalty_force (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               pair_mode,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic [30:0]        a_radius,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic [30:0]        b_radius,
    input  logic signed [18:0] normal_x,
    input  logic signed [18:0] normal_y,
    input  logic signed [18:0] normal_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] depth_x,
    output logic signed [31:0] depth_y,
    output logic signed [31:0] depth_z,
    output logic signed [31:0] contact_x,
    output logic signed [31:0] contact_y,
    output logic signed [31:0] contact_z,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic signed [31:0] force_z
);
    import scpf_pkg::*;

    logic        en;
    logic [15:0] stiffness_reg;

    // Front stages.
    side_t       s1_next, s1_reg, s2_reg, s3_reg, s4_next, s4_reg;
    logic        s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic [65:0] sq_next [3];
    logic [65:0] sq_reg  [3];
    logic signed [51:0] dn_next [3];
    logic signed [51:0] dn_reg  [3];
    logic [63:0] ssq_next, ssq_reg, ssq3_reg;
    logic [65:0] acc_next, acc_reg;
    logic signed [53:0] dot_next, dot_reg;
    logic [63:0] rad_next, rad_reg;

    // Square root and its side line.
    logic [31:0] root;
    side_t       sq_side_reg [SQRT_STAGES];
    logic        sq_vld_reg  [SQRT_STAGES];

    // Depth stage.
    side_t       dd_side_reg;
    logic        dd_vld_reg;
    logic [31:0] dist_next, dist_reg, depth_next, depth_reg;
    logic signed [32:0] coef_next, coef_reg, dpl_next, dpl_reg;
    prod_t       cp_next [3];
    prod_t       cp_reg  [3];

    // Product stage and dividers.
    mid_t        m_next, m_reg;
    logic        m_vld_reg;
    logic [63:0] num1_next [3];
    logic [63:0] num1_reg  [3];
    logic [63:0] num2_next [3];
    logic [63:0] num2_reg  [3];
    logic [31:0] mdist_reg;
    logic [31:0] q1 [3];
    logic [31:0] q2 [3];
    mid_t        dv_side_reg [DIV_STAGES];
    logic        dv_vld_reg  [DIV_STAGES];

    // Final stages.
    q32_t        fdv_next [3];
    q32_t        fdv_reg  [3];
    q32_t        fct_next [3];
    q32_t        fct_reg  [3];
    logic        fhit_next, fhit_reg, f_vld_reg;
    q32_t        force_next [3];
    q32_t        dep_out_reg [3];
    q32_t        ct_out_reg  [3];
    q32_t        force_out_reg [3];
    logic        hit_out_reg, out_vld_reg;

    // The whole pipeline moves as one; it halts only while a result beat waits.
    assign en        = !(out_vld_reg && out_stall);
    assign in_stall  = out_vld_reg && out_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stiffness_reg <= STIFFNESS_RESET;
        else if (cfg_valid)
            stiffness_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            dd_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < SQRT_STAGES; k++)
                sq_vld_reg[k] <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
                dv_vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            sq_vld_reg[0] <= s4_vld_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            dd_vld_reg  <= sq_vld_reg[SQRT_STAGES-1];
            m_vld_reg   <= dd_vld_reg;
            dv_vld_reg[0] <= m_vld_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            f_vld_reg   <= dv_vld_reg[DIV_STAGES-1];
            out_vld_reg <= f_vld_reg;
        end
    end

    // Stage 1: differences and radius sum.
    always_comb
    begin
        s1_next      = '0;
        s1_next.mode = pair_mode;
        s1_next.ar   = a_radius;
        s1_next.br   = b_radius;
        s1_next.sum  = {1'b0, a_radius} + {1'b0, b_radius};
        s1_next.a[0] = a_x;
        s1_next.a[1] = a_y;
        s1_next.a[2] = a_z;
        s1_next.b[0] = b_x;
        s1_next.b[1] = b_y;
        s1_next.b[2] = b_z;
        s1_next.n[0] = normal_x;
        s1_next.n[1] = normal_y;
        s1_next.n[2] = normal_z;
        s1_next.d[0] = {a_x[31], a_x} - {b_x[31], b_x};
        s1_next.d[1] = {a_y[31], a_y} - {b_y[31], b_y};
        s1_next.d[2] = {a_z[31], a_z} - {b_z[31], b_z};
    end

    // Stage 2: squares, squared radius sum and plane dot terms.
    always_comb
    begin
        logic [32:0] m;
        for (int i = 0; i < 3; i++)
        begin
            m = s1_reg.d[i][32] ? 33'(-s1_reg.d[i]) : 33'(s1_reg.d[i]);
            sq_next[i] = m * m;
            dn_next[i] = s1_reg.d[i] * s1_reg.n[i];
        end
        ssq_next = s1_reg.sum * s1_reg.sum;
    end

    // Stage 3: sums.
    always_comb
    begin
        acc_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        dot_next = 54'(dn_reg[0]) + 54'(dn_reg[1]) + 54'(dn_reg[2]);
    end

    // Stage 4: hit decision and plane distance.
    always_comb
    begin
        logic [53:0] dabs;
        logic signed [63:0] dtr;
        logic hit_ss;
        logic hit_pl;
        dabs   = dot_reg[53] ? 54'(-dot_reg) : 54'(dot_reg);
        hit_ss = acc_reg < {2'b00, ssq3_reg};
        hit_pl = dabs < {7'b0, s3_reg.ar, 16'b0};
        dtr    = trunc_q16(64'(dot_reg));
        s4_next     = s3_reg;
        s4_next.hit = s3_reg.mode ? hit_pl : hit_ss;
        s4_next.dis = dtr[31:0];
        rad_next    = acc_reg[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            ssq_reg  <= ssq_next;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_next[i];
                dn_reg[i] <= dn_next[i];
            end
            s3_reg   <= s2_reg;
            acc_reg  <= acc_next;
            dot_reg  <= dot_next;
            ssq3_reg <= ssq_reg;
            s4_reg   <= s4_next;
            rad_reg  <= rad_next;
            sq_side_reg[0] <= s4_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
                sq_side_reg[k] <= sq_side_reg[k-1];
        end
    end

    scpf_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    // Depth stage: sphere depth and offset coefficient, plane depth.
    always_comb
    begin
        side_t sd;
        logic [31:0] disabs;
        sd         = sq_side_reg[SQRT_STAGES-1];
        dist_next  = root;
        depth_next = sd.sum - root;
        coef_next  = $signed({2'b00, sd.br}) - $signed({2'b00, depth_next[31:1]});
        disabs     = sd.dis[31] ? 32'(-sd.dis) : 32'(sd.dis);
        dpl_next   = $signed({2'b00, sd.ar}) - $signed({1'b0, disabs});
        for (int i = 0; i < 3; i++)
            cp_next[i] = sd.dis * sd.n[i];
    end

    // Product stage: dividend terms for the sphere case, plane results.
    always_comb
    begin
        logic [31:0] dabs;
        logic [31:0] cabs;
        logic signed [32:0] cneg;
        logic signed [63:0] tq;
        cneg = -coef_reg;
        cabs = coef_reg[32] ? cneg[31:0] : coef_reg[31:0];
        m_next           = '0;
        m_next.mode      = dd_side_reg.mode;
        m_next.hit       = dd_side_reg.hit;
        m_next.coef_neg  = coef_reg[32];
        m_next.dist_zero = (dist_reg == 32'd0);
        for (int i = 0; i < 3; i++)
        begin
            dabs = dd_side_reg.d[i][32] ? 32'(-dd_side_reg.d[i]) : dd_side_reg.d[i][31:0];
            num1_next[i]     = depth_reg * dabs;
            num2_next[i]     = cabs * dabs;
            m_next.b[i]      = dd_side_reg.b[i];
            m_next.dneg[i]   = dd_side_reg.d[i][32];
            m_next.pd[i]     = dpl_reg * dd_side_reg.n[i];
            tq               = trunc_q16(64'(cp_reg[i]));
            m_next.ct_pl[i]  = sat32(64'(dd_side_reg.a[i]) - tq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_side_reg <= sq_side_reg[SQRT_STAGES-1];
            dist_reg    <= dist_next;
            depth_reg   <= depth_next;
            coef_reg    <= coef_next;
            dpl_reg     <= dpl_next;
            for (int i = 0; i < 3; i++)
            begin
                cp_reg[i]   <= cp_next[i];
                num1_reg[i] <= num1_next[i];
                num2_reg[i] <= num2_next[i];
            end
            m_reg     <= m_next;
            mdist_reg <= dist_reg;
            dv_side_reg[0] <= m_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                dv_side_reg[k] <= dv_side_reg[k-1];
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        scpf_div u_div_depth (
            .clk (clk),
            .en  (en),
            .num (num1_reg[g]),
            .den (mdist_reg),
            .quo (q1[g])
        );
        scpf_div u_div_offset (
            .clk (clk),
            .en  (en),
            .num (num2_reg[g]),
            .den (mdist_reg),
            .quo (q2[g])
        );
    end

    // Final stage: signs, saturation and mode select.
    always_comb
    begin
        mid_t md;
        logic signed [63:0] qv;
        logic signed [63:0] ov;
        logic signed [63:0] dv_ss;
        logic signed [63:0] off;
        md        = dv_side_reg[DIV_STAGES-1];
        fhit_next = md.hit;
        for (int i = 0; i < 3; i++)
        begin
            qv    = $signed({32'b0, q1[i]});
            ov    = $signed({32'b0, q2[i]});
            dv_ss = md.dneg[i] ? -qv : qv;
            off   = (md.coef_neg ^ md.dneg[i]) ? -ov : ov;
            if (md.dist_zero)
            begin
                dv_ss = '0;
                off   = '0;
            end
            if (!md.hit)
            begin
                fdv_next[i] = '0;
                fct_next[i] = '0;
            end
            else if (md.mode)
            begin
                fdv_next[i] = sat32(trunc_q16(64'(md.pd[i])));
                fct_next[i] = md.ct_pl[i];
            end
            else
            begin
                fdv_next[i] = sat32(dv_ss);
                fct_next[i] = sat32(64'(md.b[i]) + off);
            end
        end
    end

    // Output stage: penalty force.
    always_comb
    begin
        logic signed [48:0] fp;
        for (int i = 0; i < 3; i++)
        begin
            fp = $signed({1'b0, stiffness_reg}) * fdv_reg[i];
            force_next[i] = sat32(64'(fp));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fhit_reg    <= fhit_next;
            hit_out_reg <= fhit_reg;
            for (int i = 0; i < 3; i++)
            begin
                fdv_reg[i]       <= fdv_next[i];
                fct_reg[i]       <= fct_next[i];
                dep_out_reg[i]   <= fdv_reg[i];
                ct_out_reg[i]    <= fct_reg[i];
                force_out_reg[i] <= force_next[i];
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign hit       = hit_out_reg;
    assign depth_x   = dep_out_reg[0];
    assign depth_y   = dep_out_reg[1];
    assign depth_z   = dep_out_reg[2];
    assign contact_x = ct_out_reg[0];
    assign contact_y = ct_out_reg[1];
    assign contact_z = ct_out_reg[2];
    assign force_x   = force_out_reg[0];
    assign force_y   = force_out_reg[1];
    assign force_z   = force_out_reg[2];

    `SCPF_ASSERT_IMPLY(a_stall_reaches_input, out_valid && out_stall, in_stall)
    `SCPF_ASSERT_IMPLY(a_miss_is_zero, out_valid && !hit, depth_x == 0 && contact_x == 0 && force_x == 0)
    `SCPF_ASSERT_IMPLY(a_no_depth_no_force, out_valid && depth_y == 0, force_y == 0)
    `SCPF_ASSERT_NEXT(a_stalled_beat_holds, out_valid && out_stall, out_valid && $stable(force_z))

endmodule

// File: hdl/scpf_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module scpf_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);
    import scpf_pkg::*;

    logic [33:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];
    logic [63:0] rest_reg [SQRT_STAGES];
    logic [33:0] rem_next  [SQRT_STAGES];
    logic [31:0] root_next [SQRT_STAGES];
    logic [63:0] rest_next [SQRT_STAGES];

    always_comb
    begin
        logic [33:0] src_rem;
        logic [31:0] src_root;
        logic [63:0] src_rest;
        logic [35:0] t;
        logic [35:0] trial;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            if (k == 0)
            begin
                src_rem  = '0;
                src_root = '0;
                src_rest = rad;
            end
            else
            begin
                src_rem  = rem_reg[k-1];
                src_root = root_reg[k-1];
                src_rest = rest_reg[k-1];
            end
            t     = {src_rem, src_rest[63:62]};
            trial = {2'b00, src_root, 2'b01};
            if (t >= trial)
            begin
                rem_next[k]  = 34'(t - trial);
                root_next[k] = {src_root[30:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = t[33:0];
                root_next[k] = {src_root[30:0], 1'b0};
            end
            rest_next[k] = {src_rest[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rest_reg[k] <= rest_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

// File: hdl/scpf_div.sv
// Pipelined restoring divider, one quotient bit per stage; the quotient must fit 32 bits.
module scpf_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);
    import scpf_pkg::*;

    logic [31:0] rem_reg  [DIV_STAGES];
    logic [31:0] rest_reg [DIV_STAGES];
    logic [31:0] den_reg  [DIV_STAGES];
    logic [31:0] q_reg    [DIV_STAGES];
    logic [31:0] rem_next  [DIV_STAGES];
    logic [31:0] rest_next [DIV_STAGES];
    logic [31:0] den_next  [DIV_STAGES];
    logic [31:0] q_next    [DIV_STAGES];

    always_comb
    begin
        logic [31:0] src_rem;
        logic [31:0] src_rest;
        logic [31:0] src_den;
        logic [31:0] src_q;
        logic [32:0] t;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                src_rem  = num[63:32];
                src_rest = num[31:0];
                src_den  = den;
                src_q    = '0;
            end
            else
            begin
                src_rem  = rem_reg[k-1];
                src_rest = rest_reg[k-1];
                src_den  = den_reg[k-1];
                src_q    = q_reg[k-1];
            end
            t = {src_rem, src_rest[31]};
            if (t >= {1'b0, src_den})
            begin
                rem_next[k] = 32'(t - {1'b0, src_den});
                q_next[k]   = {src_q[30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = t[31:0];
                q_next[k]   = {src_q[30:0], 1'b0};
            end
            rest_next[k] = {src_rest[30:0], 1'b0};
            den_next[k]  = src_den;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                rest_reg[k] <= rest_next[k];
                den_reg[k]  <= den_next[k];
                q_reg[k]    <= q_next[k];
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

// File: test/testbench.sv
// Self-checking testbench for the sphere contact penalty force unit.
module testbench;
    import scpf_pkg::*;

    typedef struct packed {
        logic         mode;
        q32_t [2:0]   a;
        logic [30:0]  ar;
        q32_t [2:0]   b;
        logic [30:0]  br;
        nrm_t [2:0]   n;
    } pair_t;

    typedef struct packed {
        logic         hit;
        q32_t [2:0]   depth;
        q32_t [2:0]   contact;
        q32_t [2:0]   frc;
    } contact_t;

    typedef struct packed {
        pair_t        pair;
        logic         typed;
        contact_t     want;
    } stim_row_t;

    localparam int ONE = 65536;
    localparam logic MODE_SPHERE = 1'b0;
    localparam logic MODE_PLANE = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic pair_mode = 1'b0;
    logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
    logic [30:0] a_radius = '0;
    logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
    logic [30:0] b_radius = '0;
    logic signed [18:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic signed [31:0] depth_x, depth_y, depth_z;
    logic signed [31:0] contact_x, contact_y, contact_z;
    logic signed [31:0] force_x, force_y, force_z;

    sphere_contact_penalty_force i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pair_mode(pair_mode), .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_radius(a_radius),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_radius(b_radius),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
        .depth_x(depth_x), .depth_y(depth_y), .depth_z(depth_z),
        .contact_x(contact_x), .contact_y(contact_y), .contact_z(contact_z),
        .force_x(force_x), .force_y(force_y), .force_z(force_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [15:0] stiffness = STIFFNESS_RESET;
    contact_t pending_contacts[$];
    stim_row_t stim_rows[$];
    int unsigned beats_in = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatches = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_left = 0;
    logic cur_typed = 1'b0;
    contact_t cur_want;

    function automatic longint unsigned magnitude(input longint signed x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    function automatic q32_t clamp32(input longint signed x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // Truncating x*y/den; the operands are always small enough for 64 bits.
    function automatic longint signed scaled_quot(input longint signed x,
                                                  input longint signed y,
                                                  input longint unsigned den);
        longint unsigned q;
        q = (magnitude(x) * magnitude(y)) / den;
        return ((x < 0) != (y < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic contact_t predict_contact(input pair_t p, input logic [15:0] k);
        contact_t res;
        longint signed d[3];
        longint signed dv[3];
        longint signed ct[3];
        longint unsigned sum, s2, acc, m, sq, root_len, depth;
        longint signed coef, dot, dis, pdepth;
        logic ok;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'(p.a[i]) - longint'(p.b[i]);
            dv[i] = 0;
            ct[i] = 0;
        end
        if (p.mode == MODE_SPHERE)
        begin
            sum = p.ar + p.br;
            s2 = sum * sum;
            acc = 0;
            ok = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                if (ok)
                begin
                    m = magnitude(d[i]);
                    if (m >= sum)
                        ok = 1'b0;
                    else
                    begin
                        sq = m * m;
                        acc += sq;
                        if (acc < sq)
                            ok = 1'b0;
                    end
                end
            end
            if (ok && acc < s2)
            begin
                root_len = root64(acc);
                depth = sum - root_len;
                coef = longint'(p.br) - longint'(depth >> 1);
                res.hit = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    if (root_len != 0)
                    begin
                        dv[i] = clamp32(scaled_quot(depth, d[i], root_len));
                        ct[i] = clamp32(longint'(p.b[i]) + scaled_quot(coef, d[i], root_len));
                    end
                    else
                        ct[i] = p.b[i];
                end
            end
        end
        else
        begin
            dot = 0;
            for (int i = 0; i < 3; i++)
                dot += d[i] * longint'(p.n[i]);
            if (magnitude(dot) < (longint'(p.ar) << 16))
            begin
                dis = dot / ONE;
                pdepth = longint'(p.ar) - longint'(magnitude(dis));
                res.hit = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    dv[i] = clamp32((pdepth * longint'(p.n[i])) / ONE);
                    ct[i] = clamp32(longint'(p.a[i]) - (dis * longint'(p.n[i])) / ONE);
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            res.depth[i] = dv[i][31:0];
            res.contact[i] = ct[i][31:0];
            res.frc[i] = res.hit ? clamp32(longint'({48'd0, k}) * dv[i]) : 32'sd0;
        end
        return res;
    endfunction

    function automatic pair_t sphere_pair(input int ax, ay, az, input int unsigned ar,
                                          input int bx, by, bz, input int unsigned br);
        pair_t p;
        p = '0;
        p.mode = MODE_SPHERE;
        p.a[0] = ax; p.a[1] = ay; p.a[2] = az; p.ar = ar[30:0];
        p.b[0] = bx; p.b[1] = by; p.b[2] = bz; p.br = br[30:0];
        return p;
    endfunction

    function automatic pair_t plane_pair(input int ax, ay, az, input int unsigned ar,
                                         input int bx, by, bz, input int nx, ny, nz);
        pair_t p;
        p = sphere_pair(ax, ay, az, ar, bx, by, bz, 0);
        p.mode = MODE_PLANE;
        p.n[0] = nx[18:0]; p.n[1] = ny[18:0]; p.n[2] = nz[18:0];
        return p;
    endfunction

    function automatic contact_t outcome(input logic h, input int dx, dy, dz,
                                         input int cx, cy, cz, input int fx, fy, fz);
        contact_t c;
        c.hit = h;
        c.depth[0] = dx; c.depth[1] = dy; c.depth[2] = dz;
        c.contact[0] = cx; c.contact[1] = cy; c.contact[2] = cz;
        c.frc[0] = fx; c.frc[1] = fy; c.frc[2] = fz;
        return c;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int sh;
        q32_t off;
        p.mode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p.a[i] = $urandom;
                p.b[i] = $urandom;
                p.n[i] = 19'($urandom);
            end
            p.ar = 31'($urandom);
            p.br = 31'($urandom);
            return p;
        end
        // Centres close to each other at a random scale, so hits and misses mix.
        sh = $urandom_range(4, 31);
        for (int i = 0; i < 3; i++)
        begin
            p.b[i] = $urandom;
            off = $urandom;
            p.a[i] = p.b[i] + (off >>> (32 - sh));
        end
        p.ar = 31'($urandom >> (32 - sh));
        p.br = 31'($urandom >> (32 - sh));
        case ($urandom_range(0, 3))
            0:
            begin
                p.n = '0;
                p.n[$urandom_range(0, 2)] = 19'($urandom_range(0, 1) ? ONE : -ONE);
            end
            1, 2:
                for (int i = 0; i < 3; i++)
                    p.n[i] = 19'(int'($urandom_range(0, 2 * ONE)) - ONE);
            default:
                for (int i = 0; i < 3; i++)
                    p.n[i] = 19'($urandom);
        endcase
        return p;
    endfunction

    // Input side: a beat is taken when valid is high and stall is low.
    always @(posedge clk)
    begin
        pair_t p;
        contact_t next_want;
        if (rst_n && in_valid && !in_stall)
        begin
            p.mode = pair_mode;
            p.a[0] = a_x; p.a[1] = a_y; p.a[2] = a_z; p.ar = a_radius;
            p.b[0] = b_x; p.b[1] = b_y; p.b[2] = b_z; p.br = b_radius;
            p.n[0] = normal_x; p.n[1] = normal_y; p.n[2] = normal_z;
            next_want = cur_typed ? cur_want : predict_contact(p, stiffness);
            pending_contacts = {pending_contacts, next_want};
            beats_in++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            stiffness = cfg_data;
            cfg_writes++;
        end
    end

    always @(posedge clk)
    begin
        contact_t got;
        contact_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.hit = hit;
            got.depth[0] = depth_x; got.depth[1] = depth_y; got.depth[2] = depth_z;
            got.contact[0] = contact_x; got.contact[1] = contact_y;
            got.contact[2] = contact_z;
            got.frc[0] = force_x; got.frc[1] = force_y; got.frc[2] = force_z;
            if (pending_contacts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat at %0t", $time);
            end
            else
            begin
                want = pending_contacts.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: hit %0b/%0b",
                                  " depth %0d %0d %0d / %0d %0d %0d",
                                  " contact %0d %0d %0d / %0d %0d %0d",
                                  " force %0d %0d %0d / %0d %0d %0d"},
                            $time, want.hit, got.hit,
                            want.depth[0], want.depth[1], want.depth[2],
                            got.depth[0], got.depth[1], got.depth[2],
                            want.contact[0], want.contact[1], want.contact[2],
                            got.contact[0], got.contact[1], got.contact[2],
                            want.frc[0], want.frc[1], want.frc[2],
                            got.frc[0], got.frc[1], got.frc[2]);
                end
            end
        end
    end

    // Output side: random stall, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle);
    end

    task automatic send_pair(input pair_t p, input logic typed, input contact_t want);
        int unsigned seen;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur_typed = typed;
        cur_want = want;
        pair_mode <= p.mode;
        a_x <= p.a[0]; a_y <= p.a[1]; a_z <= p.a[2]; a_radius <= p.ar;
        b_x <= p.b[0]; b_y <= p.b[1]; b_z <= p.b[2]; b_radius <= p.br;
        normal_x <= p.n[0]; normal_y <= p.n[1]; normal_z <= p.n[2];
        in_valid <= 1'b1;
        seen = beats_in;
        do
            @(negedge clk);
        while (beats_in == seen);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_contacts.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_stiffness(input logic [15:0] value);
        int unsigned seen;
        drain();
        repeat (75) @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        seen = cfg_writes;
        do
            @(negedge clk);
        while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair(), 1'b0, '0);
    endtask

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        // Far apart, exactly touching and zero radii: no contact.
        row = '{sphere_pair(10 * ONE, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, '0};
        stim_rows = {stim_rows, row};
        row = '{sphere_pair(2 * ONE, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, '0};
        stim_rows = {stim_rows, row};
        row = '{sphere_pair(5, 6, 7, 0, 5, 6, 7, 0), 1'b1, '0};
        stim_rows = {stim_rows, row};
        // Coincident centres give a zero direction and contact at B.
        row = '{sphere_pair(ONE, 2 * ONE, 3 * ONE, ONE, ONE, 2 * ONE, 3 * ONE, ONE), 1'b1,
                outcome(1'b1, 0, 0, 0, ONE, 2 * ONE, 3 * ONE, 0, 0, 0)};
        stim_rows = {stim_rows, row};
        row = '{sphere_pair(ONE, 0, 0, ONE, 0, 0, 0, ONE), 1'b1,
                outcome(1'b1, ONE, 0, 0, ONE / 2, 0, 0, 400 * ONE, 0, 0)};
        stim_rows = {stim_rows, row};
        row = '{sphere_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF), 1'b0, '0};
        stim_rows = {stim_rows, row};
        row = '{sphere_pair(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                            32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF), 1'b0, '0};
        stim_rows = {stim_rows, row};
        row = '{sphere_pair(-3 * ONE, 40000, -7, 31'h7FFFFFFF, 9 * ONE, -5, 3, 31'h7FFFFFFF),
                1'b0, '0};
        stim_rows = {stim_rows, row};
        row = '{sphere_pair(-ONE, -ONE, ONE / 3, 2 * ONE, 0, 0, 0, ONE / 2), 1'b0, '0};
        stim_rows = {stim_rows, row};
        // Plane cases: centre on the plane, below it, missing it, odd normals.
        row = '{plane_pair(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE), 1'b1,
                outcome(1'b1, 0, 0, ONE, 0, 0, 0, 0, 0, 400 * ONE)};
        stim_rows = {stim_rows, row};
        row = '{plane_pair(0, 0, -ONE / 2, ONE, 0, 0, 0, 0, 0, ONE), 1'b0, '0};
        stim_rows = {stim_rows, row};
        row = '{plane_pair(0, 0, 10 * ONE, ONE, 0, 0, 0, 0, 0, ONE), 1'b1, '0};
        stim_rows = {stim_rows, row};
        row = '{plane_pair(ONE, 2, 3, 3 * ONE, 0, 0, 0, -262144, 262143, -1), 1'b0, '0};
        stim_rows = {stim_rows, row};
        row = '{plane_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF,
                           32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0), 1'b0, '0};
        stim_rows = {stim_rows, row};
        row = '{plane_pair(32'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 32'h7FFFFFF0, 0, 0,
                           262143, 262143, 262143), 1'b0, '0};
        stim_rows = {stim_rows, row};
        row = '{plane_pair(-ONE, ONE, 0, ONE, 0, 0, 0, -ONE, 0, 0), 1'b0, '0};
        row.pair.br = 31'h7FFFFFFF;
        stim_rows = {stim_rows, row};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle = 28;
        rx_idle = 88;
        foreach (stim_rows[i])
            send_pair(stim_rows[i].pair, stim_rows[i].typed, stim_rows[i].want);
        send_random(370);

        write_stiffness(16'hFFFF);
        tx_idle = 88;
        rx_idle = 28;
        // Hold the output long enough for the pipeline to fill and push back.
        hold_left = 300;
        tx_idle = 0;
        send_random(150);
        tx_idle = 88;
        send_random(230);

        write_stiffness(16'd0);
        tx_idle = 0;
        rx_idle = 0;
        send_random(190);
        write_stiffness(16'd1);
        send_random(10);
        write_stiffness(16'($urandom_range(0, 65535)));
        send_random(180);

        drain();
        repeat (80) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/scpf_pkg.sv
hdl/scpf_isqrt.sv
hdl/scpf_div.sv
hdl/sphere_contact_penalty_force.sv
test/testbench.sv
